/* rtl/sdofm_pkg.sv */
package sdofm_pkg;

  localparam int QueueDepth = 4;

  localparam logic [3:0] FrameLast = 4'd9;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WR8   = 3'd1;
  localparam logic [2:0] CMD_WR16  = 3'd2;
  localparam logic [2:0] CMD_WR32  = 3'd3;
  localparam logic [2:0] CMD_RXB   = 3'd4;

  localparam logic [7:0] CODE_READ   = 8'h40;
  localparam logic [7:0] CODE_WR8    = 8'h2F;
  localparam logic [7:0] CODE_WR16   = 8'h2B;
  localparam logic [7:0] CODE_WR32   = 8'h23;
  localparam logic [7:0] CODE_WR_OK  = 8'h60;
  localparam logic [7:0] CODE_RD32   = 8'h43;
  localparam logic [7:0] CODE_RD16   = 8'h4B;
  localparam logic [7:0] CODE_RD8    = 8'h4F;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_WR_REJ  = 2'd1;
  localparam logic [1:0] ST_RD_BAD  = 2'd2;

  localparam logic [1:0] RW_NONE = 2'd0;
  localparam logic [1:0] RW_BYTE = 2'd1;
  localparam logic [1:0] RW_HALF = 2'd2;
  localparam logic [1:0] RW_WORD = 2'd3;

  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_CPL = 1'b1;

  // one queued job: a whole frame to send, or an exchange completion
  typedef struct packed {
    logic        kind;
    logic [7:0]  node;
    logic [7:0]  code;
    logic [15:0] index;
    logic [7:0]  sub;
    logic [31:0] data;
    logic [7:0]  chk;
    logic [1:0]  status;
    logic [1:0]  rwidth;
  } job_t;

endpackage

/* rtl/sdofm_front.sv */
module sdofm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [71:0]       in_tdata,
  input  logic [2:0]        in_tuser,
  output logic              push,
  output sdofm_pkg::job_t   push_job,
  input  logic              q_full
);

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_READ  = 2'd1;
  localparam logic [1:0] PEND_WRITE = 2'd2;

  logic [1:0]  pend_r, pend_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [31:0] data_r, data_nxt;

  logic        acc, is_req, is_rx, rx_done;
  logic [2:0]  cmd;
  logic [7:0]  node, sub, rxb, fcode, sum;
  logic [15:0] idx;
  logic [31:0] wval, fdata;
  sdofm_pkg::job_t frame_job, cpl_job;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign cmd       = in_tuser;
  assign node      = in_tdata[7:0];
  assign idx       = in_tdata[23:8];
  assign sub       = in_tdata[31:24];
  assign wval      = in_tdata[63:32];
  assign rxb       = in_tdata[71:64];

  assign is_req  = (cmd <= sdofm_pkg::CMD_WR32);
  assign is_rx   = (cmd == sdofm_pkg::CMD_RXB) && (pend_r != PEND_NONE);
  assign rx_done = is_rx && (cnt_r == sdofm_pkg::FrameLast);

  always_comb begin
    unique case (cmd)
      sdofm_pkg::CMD_READ: begin
        fcode = sdofm_pkg::CODE_READ;
        fdata = '0;
      end
      sdofm_pkg::CMD_WR8: begin
        fcode = sdofm_pkg::CODE_WR8;
        fdata = {24'd0, wval[7:0]};
      end
      sdofm_pkg::CMD_WR16: begin
        fcode = sdofm_pkg::CODE_WR16;
        fdata = {16'd0, wval[15:0]};
      end
      default: begin
        fcode = sdofm_pkg::CODE_WR32;
        fdata = wval;
      end
    endcase
  end

  assign sum = node + fcode + idx[7:0] + idx[15:8] + sub
             + fdata[7:0] + fdata[15:8] + fdata[23:16] + fdata[31:24];

  always_comb begin
    frame_job        = '0;
    frame_job.kind   = sdofm_pkg::KIND_TX;
    frame_job.node   = node;
    frame_job.code   = fcode;
    frame_job.index  = idx;
    frame_job.sub    = sub;
    frame_job.data   = fdata;
    frame_job.chk    = 8'd0 - sum;
  end

  always_comb begin
    cpl_job      = '0;
    cpl_job.kind = sdofm_pkg::KIND_CPL;
    if (pend_r == PEND_WRITE) begin
      cpl_job.status = (code_r == sdofm_pkg::CODE_WR_OK) ? sdofm_pkg::ST_OK
                                                         : sdofm_pkg::ST_WR_REJ;
    end else begin
      unique case (code_r)
        sdofm_pkg::CODE_RD32: begin
          cpl_job.data   = data_r;
          cpl_job.rwidth = sdofm_pkg::RW_WORD;
        end
        sdofm_pkg::CODE_RD16: begin
          cpl_job.data   = {16'd0, data_r[15:0]};
          cpl_job.rwidth = sdofm_pkg::RW_HALF;
        end
        sdofm_pkg::CODE_RD8: begin
          cpl_job.data   = {24'd0, data_r[7:0]};
          cpl_job.rwidth = sdofm_pkg::RW_BYTE;
        end
        default: cpl_job.status = sdofm_pkg::ST_RD_BAD;
      endcase
    end
  end

  assign push     = acc && (is_req || rx_done);
  assign push_job = is_req ? frame_job : cpl_job;

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    code_nxt = code_r;
    data_nxt = data_r;
    if (acc && is_req) begin
      pend_nxt = (cmd == sdofm_pkg::CMD_READ) ? PEND_READ : PEND_WRITE;
      cnt_nxt  = '0;
      code_nxt = '0;
      data_nxt = '0;
    end else if (acc && rx_done) begin
      pend_nxt = PEND_NONE;
      cnt_nxt  = '0;
      code_nxt = '0;
      data_nxt = '0;
    end else if (acc && is_rx) begin
      cnt_nxt = cnt_r + 4'd1;
      case (cnt_r)
        4'd1: code_nxt = rxb;
        4'd5: data_nxt[7:0]   = rxb;
        4'd6: data_nxt[15:8]  = rxb;
        4'd7: data_nxt[23:16] = rxb;
        4'd8: data_nxt[31:24] = rxb;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      cnt_r  <= '0;
      code_r <= '0;
      data_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      code_r <= code_nxt;
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/sdofm_queue.sv */
module sdofm_queue #(
  parameter int DEPTH = sdofm_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sdofm_pkg::job_t  push_job,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output sdofm_pkg::job_t  head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sdofm_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/sdofm_back.sv */
module sdofm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  sdofm_pkg::job_t   head_job,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,
  output logic [0:0]        out_tuser,
  output logic              out_tlast
);

  logic        ov_r;
  logic [3:0]  bi_r, bi_nxt;
  logic        kind_r, last_r;
  logic [7:0]  byte_r;
  logic [1:0]  status_r, width_r;
  logic [31:0] value_r;
  logic        load, is_cpl, end_job;
  logic [7:0]  fbyte;

  assign load    = head_valid && (!ov_r || out_tready);
  assign is_cpl  = (head_job.kind == sdofm_pkg::KIND_CPL);
  assign end_job = is_cpl || (bi_r == sdofm_pkg::FrameLast);
  assign pop     = load && end_job;

  always_comb begin
    case (bi_r)
      4'd0: fbyte = head_job.node;
      4'd1: fbyte = head_job.code;
      4'd2: fbyte = head_job.index[7:0];
      4'd3: fbyte = head_job.index[15:8];
      4'd4: fbyte = head_job.sub;
      4'd5: fbyte = head_job.data[7:0];
      4'd6: fbyte = head_job.data[15:8];
      4'd7: fbyte = head_job.data[23:16];
      4'd8: fbyte = head_job.data[31:24];
      default: fbyte = head_job.chk;
    endcase
  end

  always_comb begin
    bi_nxt = bi_r;
    if (load) begin
      bi_nxt = end_job ? 4'd0 : bi_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      bi_r <= '0;
    end else begin
      bi_r <= bi_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head_job.kind;
      if (is_cpl) begin
        byte_r   <= '0;
        last_r   <= 1'b0;
        status_r <= head_job.status;
        value_r  <= head_job.data;
        width_r  <= head_job.rwidth;
      end else begin
        byte_r   <= fbyte;
        last_r   <= (bi_r == sdofm_pkg::FrameLast);
        status_r <= sdofm_pkg::ST_OK;
        value_r  <= '0;
        width_r  <= sdofm_pkg::RW_NONE;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, width_r, value_r, status_r, byte_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

/* rtl/sdo_serial_frame_master.sv */
// Path: the first frame byte or a completion word passes the job queue and then the
//   output register before it shows on out_tvalid.
// Throughput: a request sends a ten-byte frame, one frame byte per cycle while
//   out_tready is high; received bytes are taken one per cycle until the job queue fills.
// Reset: rst_n synchronous, active low; clears pending exchange, queue and output.
module sdo_serial_frame_master #(
  parameter int QUEUE_DEPTH = sdofm_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // node_id, object_index, object_subindex, write_value, rx_byte
  input  logic [2:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // tx_byte, status, read_value, read_width, zero pad
  output logic [0:0]  out_tuser,  // result_kind
  output logic        out_tlast
);

  logic            push, q_full, pop, head_valid;
  sdofm_pkg::job_t push_job, head_job;

  sdofm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  sdofm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sdofm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
